// ----- rtl/fla_pkg.sv -----
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and codes for the fixed-pool free-list allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_POOL_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_NONE_USED  = 2'd2;

    // Field widths
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;
    localparam int TOTAL_W = 32;

    // Saturation limit of the in-use count
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               opcode;
        logic [INDEX_W-1:0] free_index;
    } fla_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] granted_index;
        logic [COUNT_W-1:0] in_use_count;
        logic [COUNT_W-1:0] peak_in_use;
        logic [TOTAL_W-1:0] alloc_total;
    } fla_rsp_t;

endpackage

// ----- rtl/fixed_pool_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// fixed_pool_free_list_allocator_top
// LIFO free-list allocator over a pool of ENTRIES entries, links in a
// synchronous link memory.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps every entry of the link memory and
// holds busy high meanwhile. A request is taken at a rising edge with start
// high and busy low; busy then stays high while the head link read from the
// link memory is applied, so a new request is taken only after the last one
// completes. The result appears on result with done high for exactly one
// cycle, the same cycle in which busy falls; there is no backpressure, so the
// receiver must take it in that cycle.
module fixed_pool_free_list_allocator_top
    import fla_pkg::*;
#(
    parameter int ENTRIES = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  fla_req_t request,
    output logic     done,
    output fla_rsp_t result
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LINK_W = IDX_W + 1;   // top bit marks end of list
    localparam int TBL_N  = 1 << INDEX_W;

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Sequencer and request hold
    logic [1:0]       state_reg, state_next;
    logic             op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] init_cnt_reg, init_cnt_next;

    // Allocator state
    logic [IDX_W-1:0]   head_reg, head_next;
    logic               head_valid_reg, head_valid_next;
    logic [COUNT_W-1:0] use_reg, use_next;
    logic [COUNT_W-1:0] peak_reg, peak_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    // Result register
    logic     done_reg;
    fla_rsp_t rsp_reg, rsp_next;

    // Link memory
    logic [LINK_W-1:0] link_mem [ENTRIES];
    logic [LINK_W-1:0] link_rd_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;

    // Free index reduced modulo the pool size
    logic [IDX_W-1:0] mod_tbl [TBL_N];
    logic             accept;

    for (genvar g = 0; g < TBL_N; g++)
    begin : g_mod
        assign mod_tbl[g] = IDX_W'(g % ENTRIES);
    end

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    // Drive the link memory write port: initial link sweep or free push
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = head_valid_reg ? {1'b0, head_reg} : {1'b1, {IDX_W{1'b0}}};
        if (state_reg == ST_INIT)
        begin
            mem_we    = 1'b1;
            mem_waddr = init_cnt_reg;
            mem_wdata = (init_cnt_reg == '0) ? {1'b1, {IDX_W{1'b0}}}
                                             : {1'b0, init_cnt_reg - 1'b1};
        end
        else if (state_reg == ST_EXEC && op_reg == OP_FREE && use_reg != '0)
        begin
            mem_we = 1'b1;
        end
    end

    // Write and read the link memory; read the current head every cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        link_rd_reg <= link_mem[head_reg];
    end

    // Work out the next state and the result of the held request
    always_comb
    begin
        state_next      = state_reg;
        init_cnt_next   = init_cnt_reg;
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        use_next        = use_reg;
        peak_next       = peak_reg;
        total_next      = total_reg;
        rsp_next        = rsp_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                init_cnt_next = init_cnt_reg + 1'b1;
                if (init_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next             = ST_IDLE;
                rsp_next.status        = STATUS_OK;
                rsp_next.granted_index = '0;
                if (op_reg == OP_ALLOC)
                begin
                    if (!head_valid_reg)
                    begin
                        rsp_next.status = STATUS_POOL_EMPTY;
                    end
                    else
                    begin
                        rsp_next.granted_index = INDEX_W'(head_reg);
                        if (link_rd_reg[IDX_W])
                        begin
                            head_valid_next = 1'b0;
                        end
                        else
                        begin
                            head_next = link_rd_reg[IDX_W-1:0];
                        end
                        total_next = total_reg + 1'b1;
                        if (use_reg != COUNT_MAX)
                        begin
                            use_next = use_reg + 1'b1;
                        end
                        if (use_next > peak_reg)
                        begin
                            peak_next = use_next;
                        end
                    end
                end
                else
                begin
                    if (use_reg == '0)
                    begin
                        rsp_next.status = STATUS_NONE_USED;
                    end
                    else
                    begin
                        use_next        = use_reg - 1'b1;
                        head_next       = idx_reg;
                        head_valid_next = 1'b1;
                    end
                end
                rsp_next.in_use_count = use_next;
                rsp_next.peak_in_use  = peak_next;
                rsp_next.alloc_total  = total_next;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control and allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            init_cnt_reg   <= '0;
            head_reg       <= LAST_IDX;
            head_valid_reg <= 1'b1;
            use_reg        <= '0;
            peak_reg       <= '0;
            total_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_cnt_reg   <= init_cnt_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            use_reg        <= use_next;
            peak_reg       <= peak_next;
            total_reg      <= total_next;
            done_reg       <= (state_reg == ST_EXEC);
        end
    end

    // Capture the request and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= request.opcode;
            idx_reg <= mod_tbl[request.free_index];
        end
        rsp_reg <= rsp_next;
    end

    // Every executed request yields exactly one result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> done_reg)
        else $error("missing result after execute");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_EXEC))
        else $error("result without request");

    assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= use_reg)
        else $error("peak below in-use count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && op_reg == OP_ALLOC && head_valid_reg)
        |=> (total_reg == $past(total_reg) + 1'b1))
        else $error("allocation total not advanced");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && op_reg == OP_FREE && use_reg == '0)
        |=> (rsp_reg.status == STATUS_NONE_USED && $stable(use_reg)
             && $stable(head_reg)))
        else $error("free with nothing in use changed state");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-pool free-list allocator. A directed
// script covers reset order, LIFO reuse and the nothing-in-use error. Random
// phases follow. The first drains the pool past empty and then runs
// well-formed alloc/free traffic. The last issues random allocs and frees,
// including already-free entries, ties an entry into a self-loop and
// allocates until the in-use count saturates. Every result is checked
// against a typed script result or a bench-side allocator model.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fla_pkg::*;

    localparam int POOL_SIZE      = 256;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CLEAN_ITEMS    = 480;
    localparam int NOISE_ITEMS    = 40;
    localparam int SATURATE_ALLOC = 520;

    typedef struct packed {
        fla_req_t req;
        logic     fixed;
        fla_rsp_t rsp;
    } script_row_t;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    fla_req_t request = '0;
    logic     busy;
    logic     done;
    fla_rsp_t result;

    // Allocator model state
    logic [COUNT_W-1:0] link_mem [POOL_SIZE];
    logic [COUNT_W-1:0] head;
    logic               head_ok;
    logic [COUNT_W-1:0] in_use;
    logic [COUNT_W-1:0] peak;
    logic [TOTAL_W-1:0] grant_count;

    fla_rsp_t           pending_results [$];
    logic [INDEX_W-1:0] live_grants [$];
    logic               idle_on = 1'b1;
    int                 errors  = 0;
    int                 sent    = 0;
    int                 quiet_cycles = 0;

    script_row_t script [14];

    fixed_pool_free_list_allocator_top #(.ENTRIES(POOL_SIZE)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #2 clk = ~clk;

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    // Apply one request to the model and return the result it gives
    function automatic fla_rsp_t predict_grant(input fla_req_t r);
        fla_rsp_t           rsp;
        logic [COUNT_W-1:0] nxt;
        rsp = '0;
        rsp.status = STATUS_OK;
        if (r.opcode == OP_ALLOC)
        begin
            if (!head_ok || head >= POOL_SIZE)
                rsp.status = STATUS_POOL_EMPTY;
            else
            begin
                rsp.granted_index = head[INDEX_W-1:0];
                nxt = link_mem[head[INDEX_W-1:0]];
                if (nxt < POOL_SIZE)
                    head = nxt;
                else
                    head_ok = 1'b0;
                grant_count = grant_count + 1'b1;
                if (in_use != COUNT_MAX)
                    in_use = in_use + 1'b1;
                if (in_use > peak)
                    peak = in_use;
            end
        end
        else if (in_use == 0)
            rsp.status = STATUS_NONE_USED;
        else
        begin
            in_use = in_use - 1'b1;
            link_mem[r.free_index] = head_ok ? head : COUNT_W'(POOL_SIZE);
            head    = {1'b0, r.free_index};
            head_ok = 1'b1;
        end
        rsp.in_use_count = in_use;
        rsp.peak_in_use  = peak;
        rsp.alloc_total  = grant_count;
        return rsp;
    endfunction

    // Drive one request, hold it until taken, then queue its expected result
    task automatic issue_request(input fla_req_t r, input logic fixed, input fla_rsp_t fixed_rsp);
        fla_rsp_t rsp;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rsp = predict_grant(r);
        pending_results.push_back(fixed ? fixed_rsp : rsp);
        sent++;
        // Track which entries are held so clean frees return real grants
        if (r.opcode == OP_ALLOC && rsp.status == STATUS_OK)
            live_grants.push_back(rsp.granted_index);
        if (r.opcode == OP_FREE && rsp.status == STATUS_OK)
        begin
            for (int k = 0; k < live_grants.size(); k++)
            begin
                if (live_grants[k] == r.free_index)
                begin
                    live_grants.delete(k);
                    break;
                end
            end
        end
    endtask

    task automatic issue_alloc();
        fla_req_t r;
        r.opcode     = OP_ALLOC;
        r.free_index = INDEX_W'($urandom_range(0, 255));
        issue_request(r, 1'b0, '0);
    endtask

    task automatic issue_free(input logic [INDEX_W-1:0] idx);
        fla_req_t r;
        r.opcode     = OP_FREE;
        r.free_index = idx;
        issue_request(r, 1'b0, '0);
    endtask

    // Return a held entry, or hit the nothing-in-use case when none is held
    task automatic free_held();
        if (live_grants.size() == 0)
            issue_free(INDEX_W'($urandom_range(0, 255)));
        else
            issue_free(live_grants[$urandom_range(0, live_grants.size() - 1)]);
    endtask

    // Check each result against the oldest pending request
    always @(posedge clk)
    begin
        fla_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report("result with no request pending");
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report($sformatf("status got %0d want %0d", result.status, want.status));
                if (result.granted_index !== want.granted_index)
                    report($sformatf("granted_index got %0d want %0d",
                                     result.granted_index, want.granted_index));
                if (result.in_use_count !== want.in_use_count)
                    report($sformatf("in_use_count got %0d want %0d",
                                     result.in_use_count, want.in_use_count));
                if (result.peak_in_use !== want.peak_in_use)
                    report($sformatf("peak_in_use got %0d want %0d",
                                     result.peak_in_use, want.peak_in_use));
                if (result.alloc_total !== want.alloc_total)
                    report($sformatf("alloc_total got %0d want %0d",
                                     result.alloc_total, want.alloc_total));
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("fixed_pool_free_list_allocator_top test failed");
            $finish;
        end
    end

    initial
    begin
        int run_len;
        int mode;

        // Model reset: entry i links to i-1, entry 0 ends the list
        link_mem[0] = COUNT_W'(POOL_SIZE);
        for (int i = 1; i < POOL_SIZE; i++)
            link_mem[i] = COUNT_W'(i - 1);
        head        = COUNT_W'(POOL_SIZE - 1);
        head_ok     = 1'b1;
        in_use      = '0;
        peak        = '0;
        grant_count = '0;

        // Directed script; typed results where they follow from reset order
        script = '{
            '{'{OP_FREE,  8'd0},   1'b1, '{STATUS_NONE_USED, 8'd0,   9'd0, 9'd0, 32'd0}},
            '{'{OP_ALLOC, 8'd0},   1'b1, '{STATUS_OK,        8'd255, 9'd1, 9'd1, 32'd1}},
            '{'{OP_ALLOC, 8'd255}, 1'b1, '{STATUS_OK,        8'd254, 9'd2, 9'd2, 32'd2}},
            '{'{OP_FREE,  8'd255}, 1'b1, '{STATUS_OK,        8'd0,   9'd1, 9'd2, 32'd2}},
            '{'{OP_ALLOC, 8'd0},   1'b1, '{STATUS_OK,        8'd255, 9'd2, 9'd2, 32'd3}},
            '{'{OP_FREE,  8'd254}, 1'b0, '0},
            '{'{OP_FREE,  8'd255}, 1'b1, '{STATUS_OK,        8'd0,   9'd0, 9'd2, 32'd3}},
            '{'{OP_FREE,  8'd255}, 1'b1, '{STATUS_NONE_USED, 8'd0,   9'd0, 9'd2, 32'd3}},
            '{'{OP_ALLOC, 8'd128}, 1'b0, '0},
            '{'{OP_ALLOC, 8'd127}, 1'b0, '0},
            '{'{OP_ALLOC, 8'd1},   1'b0, '0},
            '{'{OP_FREE,  8'd255}, 1'b0, '0},
            '{'{OP_FREE,  8'd253}, 1'b0, '0},
            '{'{OP_ALLOC, 8'd0},   1'b0, '0}
        };

        // Hold reset, then release it at a clock edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            issue_request(script[i].req, script[i].fixed, script[i].rsp);

        // Drain the pool past empty
        idle_on = 1'($urandom_range(0, 1));
        repeat (POOL_SIZE + 6)
            issue_alloc();

        // Well-formed traffic: alloc runs and returns of held entries
        while (sent < CLEAN_ITEMS)
        begin
            idle_on = ($urandom_range(0, 2) != 0);
            mode    = $urandom_range(0, 5);
            run_len = $urandom_range(1, 40);
            case (mode)
                0, 1:
                    repeat (run_len) issue_alloc();
                2, 3:
                    repeat (run_len) free_held();
                4:
                begin
                    while (live_grants.size() != 0)
                        free_held();
                    free_held();
                end
                default:
                    repeat ($urandom_range(1, 120)) issue_alloc();
            endcase
        end

        // Pause until every pending result is back
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        // Noise: random opcodes and indexes, including already-free entries
        idle_on = 1'b1;
        repeat (NOISE_ITEMS)
        begin
            if ($urandom_range(0, 1) == 0)
                issue_alloc();
            else
                issue_free(INDEX_W'($urandom_range(0, 255)));
        end

        // Free the head entry again to tie it into a self-loop
        while (!(head_ok && link_mem[head[INDEX_W-1:0]] == head))
        begin
            if (in_use == 0)
                issue_alloc();
            else if (!head_ok)
                issue_free(INDEX_W'($urandom_range(0, 255)));
            else
                issue_free(head[INDEX_W-1:0]);
        end

        // Allocate through the loop until the in-use count saturates
        idle_on = 1'b0;
        repeat (SATURATE_ALLOC)
            issue_alloc();
        repeat (4)
            issue_free(INDEX_W'($urandom_range(0, 255)));

        // Drain and settle
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("fixed_pool_free_list_allocator_top test passed");
        else
            $display("fixed_pool_free_list_allocator_top test failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/fla_pkg.sv
rtl/fixed_pool_free_list_allocator_top.sv
test/tb.sv
